/* rtl/core/nrle_pkg.sv */
// ----------------------------------------------------------------------------
// nrle_pkg
// Shared types, constants and helpers of the nibble run-length row decoder.
// ----------------------------------------------------------------------------
package nrle_pkg;

	// row geometry: columns at or past ROW_WIDTH are never written
	localparam int unsigned ROW_WIDTH = 256;
	// column counter holds ROW_WIDTH itself
	localparam int unsigned COL_W = 9;

	// header bytes counted in the declared run length
	localparam logic [7:0] HDR_BYTES = 8'd4;
	// length nibbles up to this value announce literal groups
	localparam logic [3:0] LIT_MAX = 4'd7;
	// repeat count is the length nibble minus this bias
	localparam logic [3:0] REP_BIAS = 4'd6;

	// item kinds
	localparam logic KIND_HDR = 1'b0;

	// decoder phase within a run
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_LEN  = 2'd1,
		PH_LIT  = 2'd2,
		PH_REP  = 2'd3
	} phase_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERRUN  = 2'd1,
		ST_MISMATCH = 2'd2,
		ST_COL_OVF  = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic load_hdr;
		logic load_byte;
		logic nib;
		logic rep;
		logic ovr;
		logic sel_lo;
	} nrle_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic can_emit;
		logic active;
		logic go_rep;
		logic go_ovr;
		logic live;
		logic rep_done;
	} nrle_stat_t;

	// true if the byte holding nibble index k lies within the declared length
	function automatic logic fits(input logic [9:0] k, input logic [7:0] len);
		logic [7:0] avail;
		avail = (len >= HDR_BYTES) ? (len - HDR_BYTES) : 8'd0;
		return k[9:1] < {1'b0, avail};
	endfunction

endpackage

/* rtl/core/nrle_datapath.sv */
// ----------------------------------------------------------------------------
// nrle_datapath
// Run state, nibble decode, tile emission and the result output register.
// ----------------------------------------------------------------------------
module nrle_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nrle_pkg::nrle_cmd_t  cmd,
	output nrle_pkg::nrle_stat_t st,
	input  logic [7:0]           row,
	input  logic [7:0]           start_col,
	input  logic [7:0]           end_col,
	input  logic [7:0]           data_len,
	input  logic [7:0]           data_byte,
	input  logic                 result_stall,
	output logic                 result_valid,
	output logic                 write_valid,
	output logic [7:0]           tile_row,
	output logic [7:0]           tile_col,
	output logic [3:0]           tile,
	output logic                 run_done,
	output logic [1:0]           status
);
	import nrle_pkg::*;

	logic [7:0]       row_q, row_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [7:0]       stop_q, stop_d;
	logic [7:0]       len_q, len_d;
	logic [8:0]       nc_q, nc_d;
	phase_t           phase_q, phase_d;
	logic [3:0]       left_q, left_d;
	logic             drop_q, drop_d;
	logic [7:0]       byte_q;

	logic             res_valid_q;
	logic             res_wv_q;
	logic [7:0]       res_row_q;
	logic [7:0]       res_col_q;
	logic [3:0]       res_tile_q;
	logic             res_done_q;
	status_t          res_status_q;

	logic             emit;
	logic             e_wv;
	logic [7:0]       e_row;
	logic [7:0]       e_col;
	logic [3:0]       e_tile;
	logic             e_done;
	status_t          e_status;

	logic [3:0]       nib_v;
	logic [8:0]       nc_inc;
	logic [8:0]       nc_eff;
	logic [9:0]       nc_plus;
	logic [8:0]       used;
	logic [COL_W-1:0] col_inc;
	logic             col_full;
	logic [3:0]       left_dec;
	logic             run_end;
	status_t          end_status;
	logic             do_tile;
	logic             len_ok;
	logic             go_rep;
	logic             go_ovr;
	logic             rep_done;

	always_comb begin
		nib_v      = cmd.sel_lo ? byte_q[3:0] : byte_q[7:4];
		nc_inc     = nc_q + 9'd1;
		nc_eff     = cmd.nib ? nc_inc : nc_q;
		nc_plus    = {1'b0, nc_eff} + 10'd1;
		used       = 9'(nc_plus >> 1) + {1'b0, HDR_BYTES};
		col_inc    = col_q + COL_W'(1);
		col_full   = col_q >= COL_W'(ROW_WIDTH);
		left_dec   = left_q - 4'd1;
		run_end    = col_inc >= COL_W'(stop_q);
		end_status = (used == {1'b0, len_q}) ? ST_OK : ST_MISMATCH;

		row_d    = row_q;
		col_d    = col_q;
		stop_d   = stop_q;
		len_d    = len_q;
		nc_d     = nc_q;
		phase_d  = phase_q;
		left_d   = left_q;
		drop_d   = drop_q;

		emit     = 1'b0;
		e_wv     = 1'b0;
		e_row    = row_q;
		e_col    = col_q[7:0];
		e_tile   = 4'd0;
		e_done   = 1'b0;
		e_status = ST_OK;

		do_tile  = 1'b0;
		len_ok   = 1'b1;
		go_rep   = 1'b0;
		go_ovr   = 1'b0;
		rep_done = 1'b0;

		priority if (cmd.load_hdr) begin
			row_d  = row;
			col_d  = COL_W'(start_col);
			stop_d = end_col;
			len_d  = data_len;
			nc_d   = 9'd0;
			left_d = 4'd0;
			drop_d = 1'b0;
			e_row  = row;
			e_col  = start_col;
			if (start_col >= end_col) begin
				// empty run
				emit     = 1'b1;
				e_done   = 1'b1;
				e_status = (data_len == HDR_BYTES) ? ST_OK : ST_MISMATCH;
				phase_d  = PH_IDLE;
				drop_d   = (data_len != HDR_BYTES);
			end else if (!fits(10'd0, data_len)) begin
				emit     = 1'b1;
				e_done   = 1'b1;
				e_status = ST_OVERRUN;
				phase_d  = PH_IDLE;
				drop_d   = 1'b1;
			end else begin
				phase_d = PH_LEN;
			end
		end else if (cmd.nib) begin
			nc_d = nc_inc;
			unique case (phase_q)
				PH_LEN: begin
					if (nib_v <= LIT_MAX) begin
						left_d  = nib_v + 4'd1;
						phase_d = PH_LIT;
						len_ok  = fits({1'b0, nc_inc} + {6'd0, nib_v}, len_q);
					end else begin
						left_d  = nib_v - REP_BIAS;
						phase_d = PH_REP;
						len_ok  = fits({1'b0, nc_inc}, len_q);
					end
					if (!len_ok) begin
						emit     = 1'b1;
						e_done   = 1'b1;
						e_status = ST_OVERRUN;
						phase_d  = PH_IDLE;
						drop_d   = 1'b1;
					end
				end
				PH_LIT: do_tile = 1'b1;
				PH_REP: go_rep = 1'b1;
				default: ;
			endcase
		end else if (cmd.rep) begin
			do_tile = 1'b1;
		end else if (cmd.ovr) begin
			// overrun found at the end of a group, reported in a beat of its own after the group's last tile
			emit     = 1'b1;
			e_done   = 1'b1;
			e_status = ST_OVERRUN;
			phase_d  = PH_IDLE;
			drop_d   = 1'b1;
		end else begin
			// no command: run state holds
		end

		if (do_tile) begin
			emit = 1'b1;
			if (col_full) begin
				e_done   = 1'b1;
				e_status = ST_COL_OVF;
				phase_d  = PH_IDLE;
				drop_d   = 1'b1;
				rep_done = 1'b1;
			end else begin
				e_wv   = 1'b1;
				e_tile = nib_v;
				col_d  = col_inc;
				left_d = left_dec;
				if (left_dec == 4'd0) begin
					rep_done = 1'b1;
					if (run_end) begin
						e_done   = 1'b1;
						e_status = end_status;
						phase_d  = PH_IDLE;
						drop_d   = (end_status != ST_OK);
					end else begin
						phase_d = PH_LEN;
						go_ovr  = !fits({1'b0, nc_eff}, len_q);
					end
				end
			end
		end

		st.can_emit = !res_valid_q || !result_stall;
		st.active   = (phase_q != PH_IDLE) && !drop_q;
		st.go_rep   = go_rep;
		st.go_ovr   = go_ovr;
		st.live     = (phase_d != PH_IDLE);
		st.rep_done = rep_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= 8'd0;
			col_q       <= '0;
			stop_q      <= 8'd0;
			len_q       <= HDR_BYTES;
			nc_q        <= 9'd0;
			phase_q     <= PH_IDLE;
			left_q      <= 4'd0;
			drop_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			row_q   <= row_d;
			col_q   <= col_d;
			stop_q  <= stop_d;
			len_q   <= len_d;
			nc_q    <= nc_d;
			phase_q <= phase_d;
			left_q  <= left_d;
			drop_q  <= drop_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			byte_q <= data_byte;
		end
		if (emit) begin
			res_wv_q     <= e_wv;
			res_row_q    <= e_row;
			res_col_q    <= e_col;
			res_tile_q   <= e_tile;
			res_done_q   <= e_done;
			res_status_q <= e_status;
		end
	end

	assign result_valid = res_valid_q;
	assign write_valid  = res_wv_q;
	assign tile_row     = res_row_q;
	assign tile_col     = res_col_q;
	assign tile         = res_tile_q;
	assign run_done     = res_done_q;
	assign status       = res_status_q;

	a_drop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> (phase_q == PH_IDLE))
		else $error("drop mode set while a run is active");

	a_rep_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_REP) |-> (left_q != 4'd0))
		else $error("repeat group with no tiles left");

	a_mid_run_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_done_q) |-> (res_wv_q && res_status_q == ST_OK))
		else $error("beat inside a run is not a clean tile write");

endmodule

/* rtl/core/nrle_ctrl.sv */
// ----------------------------------------------------------------------------
// nrle_ctrl
// Sequencer: item intake, nibble stepping, repeat expansion and late errors.
// ----------------------------------------------------------------------------
module nrle_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 kind,
	output logic                 item_stall,
	output nrle_pkg::nrle_cmd_t  cmd,
	input  nrle_pkg::nrle_stat_t st
);
	import nrle_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_NIB  = 4'b0010,
		S_REP  = 4'b0100,
		S_OVR  = 4'b1000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	logic        sel_lo_q, sel_lo_d;
	logic        accept;

	always_comb begin
		item_stall = !((state_q == S_IDLE) && st.can_emit);
		accept     = item_valid && !item_stall;

		cmd           = '0;
		cmd.sel_lo    = sel_lo_q;
		cmd.load_hdr  = accept && (kind == KIND_HDR);
		cmd.load_byte = accept && (kind != KIND_HDR);
		cmd.nib       = (state_q == S_NIB) && st.can_emit;
		cmd.rep       = (state_q == S_REP) && st.can_emit;
		cmd.ovr       = (state_q == S_OVR) && st.can_emit;

		state_d  = state_q;
		sel_lo_d = sel_lo_q;

		unique case (state_q)
			S_IDLE: begin
				// bytes outside an active run are dropped here
				if (cmd.load_byte && st.active) begin
					state_d  = S_NIB;
					sel_lo_d = 1'b0;
				end
			end
			S_NIB: begin
				if (cmd.nib) begin
					if (st.go_rep) begin
						state_d = S_REP;
					end else if (st.go_ovr) begin
						state_d = S_OVR;
					end else if (st.live && !sel_lo_q) begin
						state_d  = S_NIB;
						sel_lo_d = 1'b1;
					end else begin
						state_d  = S_IDLE;
						sel_lo_d = 1'b0;
					end
				end
			end
			S_REP: begin
				if (cmd.rep && st.rep_done) begin
					if (st.go_ovr) begin
						state_d = S_OVR;
					end else if (st.live && !sel_lo_q) begin
						state_d  = S_NIB;
						sel_lo_d = 1'b1;
					end else begin
						state_d  = S_IDLE;
						sel_lo_d = 1'b0;
					end
				end
			end
			S_OVR: begin
				if (cmd.ovr) begin
					state_d  = S_IDLE;
					sel_lo_d = 1'b0;
				end
			end
			default: begin
				state_d  = S_IDLE;
				sel_lo_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sel_lo_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			sel_lo_q <= sel_lo_d;
		end
	end

	a_idle_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !sel_lo_q)
		else $error("nibble select left on low nibble while idle");

	a_ovr_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OVR && st.can_emit) |=> (state_q == S_IDLE))
		else $error("overrun report did not end the byte");

endmodule

/* rtl/core/nibble_rle_row_decoder.sv */
// ----------------------------------------------------------------------------
// nibble_rle_row_decoder
// Decodes nibble run-length coded runs of a row of 4-bit tiles.
// ----------------------------------------------------------------------------
// A header beat (kind 0) opens a run: row, start column, end column and the
// run length in bytes including a 4-byte header. Data beats (kind 1) carry one
// byte, high nibble first. Length nibbles 0..7 give that many plus one literal
// tiles, 8..15 give one tile repeated nibble minus 6 times. Every tile comes
// out as one result beat with its row and column; the last beat of a run has
// run_done set and carries the run status (length mismatch shows up there).
// Length overrun and column overflow end the run with a beat of their own
// with write_valid low; after any error, data beats are swallowed until the
// next header. Data beats outside a run give no result.
// Timing: the decoder works on one item at a time and writes at most one
// result beat per cycle into a single output register. A data byte is
// accepted, then stepped nibble by nibble; each tile of a repeat group
// takes a step of its own, and a group that ends past the declared length
// adds a step for its overrun beat. The longest byte is a length nibble,
// then a nine-tile repeat whose end runs past the declared length. While
// result_stall holds a full result register, the decoder waits.
// ----------------------------------------------------------------------------
module nibble_rle_row_decoder (
	input  logic       clk,
	input  logic       arst_n,
	// item channel
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       kind,
	input  logic [7:0] row,
	input  logic [7:0] start_col,
	input  logic [7:0] end_col,
	input  logic [7:0] data_len,
	input  logic [7:0] data_byte,
	// result channel
	output logic       result_valid,
	input  logic       result_stall,
	output logic       write_valid,
	output logic [7:0] tile_row,
	output logic [7:0] tile_col,
	output logic [3:0] tile,
	output logic       run_done,
	output logic [1:0] status
);
	import nrle_pkg::*;

	// command and status between the sequencer and the datapath
	nrle_cmd_t  cmd;
	nrle_stat_t st;

	// sequencer: owns the item handshake and steps through nibbles
	nrle_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.kind       (kind),
		.item_stall (item_stall),
		.cmd        (cmd),
		.st         (st)
	);

	// datapath: run state, length checks and the result register
	nrle_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.row          (row),
		.start_col    (start_col),
		.end_col      (end_col),
		.data_len     (data_len),
		.data_byte    (data_byte),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.write_valid  (write_valid),
		.tile_row     (tile_row),
		.tile_col     (tile_col),
		.tile         (tile),
		.run_done     (run_done),
		.status       (status)
	);

endmodule
